### rtl/mscc_pkg.sv
package mscc_pkg;

	// Grid limits and the field widths derived from them.
	localparam int MAX_ROW_LENGTH = 256;
	localparam int MAX_ROWS       = 256;
	localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
	localparam int ROW_W          = $clog2(MAX_ROWS);
	localparam int RLE_W          = COL_W + 1;
	localparam int RL_W           = 9;
	localparam int SIZE_W         = 8;
	localparam int SAMPLE_W       = 16;
	localparam int COORD_W        = 17;
	localparam int CASE_W         = 4;

	// The line buffer is split into an even and an odd bank so that two
	// neighboring entries can be read and written in the same cycle.
	localparam int BANK_DEPTH = MAX_ROW_LENGTH / 2;
	localparam int BANK_AW    = COL_W - 1;

	// Output queue of cell entries; the depth must be a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [SAMPLE_W-1:0] LEVEL_THRESHOLD_RST = '0;
	localparam logic [RL_W-1:0]            ROW_LENGTH_RST      = 9'd256;
	localparam logic [SIZE_W-1:0]          CELL_SIZE_RST       = 8'd10;

	typedef enum logic [1:0] {
		REG_LEVEL_THRESHOLD = 2'd0,
		REG_ROW_LENGTH      = 2'd1,
		REG_CELL_SIZE       = 2'd2
	} reg_idx_t;

	// Corner cases with special meaning.
	localparam logic [CASE_W-1:0] CASE_EMPTY    = 4'd0;
	localparam logic [CASE_W-1:0] CASE_FULL     = 4'd15;
	localparam logic [CASE_W-1:0] CASE_SADDLE_A = 4'd5;
	localparam logic [CASE_W-1:0] CASE_SADDLE_B = 4'd10;

	// Edge midpoints of a cell.
	typedef enum logic [1:0] {
		PT_TOP    = 2'd0,
		PT_LEFT   = 2'd1,
		PT_RIGHT  = 2'd2,
		PT_BOTTOM = 2'd3
	} pt_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] level_threshold;
		logic [RL_W-1:0]            row_length;
		logic [SIZE_W-1:0]          cell_size;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [CASE_W-1:0]  cell_case;
		logic [COORD_W-1:0] gx;
		logic [COORD_W-1:0] gy;
	} cell_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} xy_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} seg_t;

	typedef struct packed {
		seg_t              first;
		seg_t              second;
		logic [CASE_W-1:0] cell_case;
		logic              two;
	} entry_t;

	typedef struct packed {
		logic two;
		pt_t  a0;
		pt_t  b0;
		pt_t  a1;
		pt_t  b1;
	} plan_t;

	// Segment endpoints for each corner case, in output order.
	function automatic plan_t seg_plan(input logic [CASE_W-1:0] cs);
		plan_t p;
		p = '{two: 1'b0, a0: PT_TOP, b0: PT_TOP, a1: PT_TOP, b1: PT_TOP};
		case (cs) inside
			4'd1, 4'd14: begin
				p.a0 = PT_TOP;
				p.b0 = PT_LEFT;
			end
			4'd2, 4'd13: begin
				p.a0 = PT_TOP;
				p.b0 = PT_RIGHT;
			end
			4'd4, 4'd11: begin
				p.a0 = PT_RIGHT;
				p.b0 = PT_BOTTOM;
			end
			4'd7, 4'd8: begin
				p.a0 = PT_BOTTOM;
				p.b0 = PT_LEFT;
			end
			4'd6, 4'd9: begin
				p.a0 = PT_TOP;
				p.b0 = PT_BOTTOM;
			end
			4'd3, 4'd12: begin
				p.a0 = PT_LEFT;
				p.b0 = PT_RIGHT;
			end
			CASE_SADDLE_A: begin
				p.two = 1'b1;
				p.a0  = PT_TOP;
				p.b0  = PT_LEFT;
				p.a1  = PT_RIGHT;
				p.b1  = PT_BOTTOM;
			end
			CASE_SADDLE_B: begin
				p.two = 1'b1;
				p.a0  = PT_TOP;
				p.b0  = PT_RIGHT;
				p.a1  = PT_BOTTOM;
				p.b1  = PT_LEFT;
			end
			default: begin
				p.two = 1'b0;
			end
		endcase
		return p;
	endfunction

	// Position of an edge midpoint; sums wrap at the coordinate width.
	function automatic xy_t point_at(input pt_t pt, input logic [COORD_W-1:0] gx,
			input logic [COORD_W-1:0] gy, input logic [COORD_W-1:0] s);
		xy_t r;
		case (pt)
			PT_TOP: begin
				r.x = gx + s;
				r.y = gy;
			end
			PT_LEFT: begin
				r.x = gx;
				r.y = gy + s;
			end
			PT_RIGHT: begin
				r.x = gx + (s << 1);
				r.y = gy + s;
			end
			default: begin
				r.x = gx + s;
				r.y = gy + (s << 1);
			end
		endcase
		return r;
	endfunction

endpackage

### rtl/mscc_if.sv
// Sample stream: one grid point per item.
interface mscc_in_if import mscc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       first_of_frame;

	modport source (output valid, output sample, output first_of_frame, input ready);
	modport sink (input valid, input sample, input first_of_frame, output ready);
endinterface

// Segment stream: one contour segment per item.
interface mscc_out_if import mscc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic [CASE_W-1:0]  cell_case;
	logic               last_segment;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, output cell_case, output last_segment, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, input cell_case, input last_segment, output ready);
endinterface

### rtl/mscc_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// A read at the address being written returns the old contents.
module mscc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/mscc_cfg.sv
// Configuration registers behind an APB-style port with no wait states.
module mscc_cfg import mscc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg    = cfg_q;

	// Register writes; an address beyond the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold <= LEVEL_THRESHOLD_RST;
			cfg_q.row_length      <= ROW_LENGTH_RST;
			cfg_q.cell_size       <= CELL_SIZE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= pwdata[SAMPLE_W-1:0];
				REG_ROW_LENGTH:      cfg_q.row_length <= pwdata[RL_W-1:0];
				REG_CELL_SIZE:       cfg_q.cell_size <= pwdata[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (idx)
			REG_LEVEL_THRESHOLD: prdata = CFG_DATA_W'(cfg_q.level_threshold);
			REG_ROW_LENGTH:      prdata = CFG_DATA_W'(cfg_q.row_length);
			REG_CELL_SIZE:       prdata = CFG_DATA_W'(cfg_q.cell_size);
			default:             prdata = '0;
		endcase
	end

endmodule

### rtl/mscc_scan.sv
// Raster position tracking, one-bit line buffer and cell formation.
// Stage 1 holds the corner bits of the new cell, stage 2 its grid origin.
module mscc_scan import mscc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       first_of_frame,
	input  cfg_t                       cfg,
	output logic                       valid_s1,
	output cell_t                      cell_s2
);

	localparam int PRODX_W = COL_W + SIZE_W;
	localparam int PRODY_W = ROW_W + SIZE_W;

	logic [COL_W-1:0]   column_count_q;
	logic [ROW_W-1:0]   row_count_q;
	logic               left_bit_q;
	logic [RLE_W-1:0]   rl_eff;
	logic [COL_W-1:0]   last_col;
	logic [COL_W-1:0]   col_raw;
	logic [COL_W-1:0]   col;
	logic [COL_W-1:0]   col_m1;
	logic [ROW_W-1:0]   row;
	logic               cur;
	logic               at_last;

	logic               bank_we    [2];
	logic [BANK_AW-1:0] bank_addr  [2];
	logic               bank_wdata [2];
	logic               bank_rdata [2];

	logic [COL_W-1:0]   col_m1_s1;
	logic [ROW_W-1:0]   row_m1_s1;
	logic               cur_s1;
	logic               left_s1;
	logic               par_s1;
	logic               form_s1;
	logic [CASE_W-1:0]  case_s1;
	logic [PRODX_W-1:0] prod_x;
	logic [PRODY_W-1:0] prod_y;

	logic               cell_valid_s2;
	logic [CASE_W-1:0]  cell_case_s2;
	logic [COORD_W-1:0] gx_s2;
	logic [COORD_W-1:0] gy_s2;

	// Effective row length, clamped to the supported range.
	always_comb begin
		if (int'(cfg.row_length) < 2) begin
			rl_eff = RLE_W'(2);
		end else if (int'(cfg.row_length) > MAX_ROW_LENGTH) begin
			rl_eff = RLE_W'(MAX_ROW_LENGTH);
		end else begin
			rl_eff = RLE_W'(cfg.row_length);
		end
	end

	// Position of the incoming sample; a stale column counts as the last one.
	always_comb begin
		last_col = COL_W'(rl_eff - RLE_W'(1));
		col_raw  = first_of_frame ? '0 : column_count_q;
		row      = first_of_frame ? '0 : row_count_q;
		col      = (col_raw > last_col) ? last_col : col_raw;
		col_m1   = col - COL_W'(1);
		at_last  = (col == last_col);
		cur      = (sample >= cfg.level_threshold);
	end

	// Line buffer banks. The entry left of the sample takes the previous bit,
	// and at the row end the sample's own entry takes the current bit.
	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic own;

		always_comb begin
			own           = (col[0] == 1'(b));
			bank_addr[b]  = own ? col[COL_W-1:1] : col_m1[COL_W-1:1];
			bank_wdata[b] = own ? cur : left_bit_q;
			bank_we[b]    = accept && (own ? at_last : (col != '0));
		end

		mscc_ram #(
			.WIDTH (1),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_addr[b]),
			.wdata (bank_wdata[b]),
			.raddr (bank_addr[b]),
			.rdata (bank_rdata[b])
		);
	end

	// Raster counters and stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
			valid_s1       <= 1'b0;
			cell_valid_s2  <= 1'b0;
		end else begin
			valid_s1      <= accept;
			cell_valid_s2 <= valid_s1 && form_s1 && (case_s1 != CASE_EMPTY) &&
				(case_s1 != CASE_FULL);
			if (accept) begin
				if (at_last) begin
					column_count_q <= '0;
					row_count_q    <= (int'(row) == MAX_ROWS - 1) ? '0 : row + ROW_W'(1);
				end else begin
					column_count_q <= col + COL_W'(1);
					row_count_q    <= row;
				end
			end
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			left_bit_q <= cur;
			col_m1_s1  <= col_m1;
			row_m1_s1  <= row - ROW_W'(1);
			cur_s1     <= cur;
			left_s1    <= left_bit_q;
			par_s1     <= col[0];
			form_s1    <= (col != '0) && (row != '0);
		end
	end

	// Corner case and grid origin of the cell.
	always_comb begin
		case_s1 = {left_s1, cur_s1, bank_rdata[par_s1], bank_rdata[!par_s1]};
		prod_x  = PRODX_W'(col_m1_s1) * PRODX_W'(cfg.cell_size);
		prod_y  = PRODY_W'(row_m1_s1) * PRODY_W'(cfg.cell_size);
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		cell_case_s2 <= case_s1;
		gx_s2        <= COORD_W'({prod_x, 1'b0});
		gy_s2        <= COORD_W'({prod_y, 1'b0});
	end

	assign cell_s2 = '{valid: cell_valid_s2, cell_case: cell_case_s2, gx: gx_s2, gy: gy_s2};

`ifndef NO_ASSERTIONS
	// A sample taken at the row end restarts the column count.
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && at_last |=> column_count_q == '0)
		else $error("column count did not wrap at the row end");

	// A cell in stage 2 comes from an item that was in stage 1.
	a_cell_origin: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid_s2 |-> $past(valid_s1))
		else $error("cell appeared without a stage 1 item");
`endif

endmodule

### rtl/mscc_queue.sv
// Segment geometry and a small queue of cell entries. A saddle entry is
// delivered as two items; input flow is throttled by reserved queue space.
module mscc_queue import mscc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  cell_t     cell_in,
	input  cfg_t      cfg,
	output logic      room,
	mscc_out_if.source segments
);

	localparam int SUM_W = QCNT_W + 1;

	entry_t             fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               sub_q;

	logic [COORD_W-1:0] s17;
	plan_t              plan;
	xy_t                pa0, pb0, pa1, pb1;
	entry_t             new_entry;
	entry_t             head;
	seg_t               seg;
	logic               push;
	logic               fire;
	logic               pop;

	// Endpoints of the cell's segments.
	always_comb begin
		s17  = COORD_W'(cfg.cell_size);
		plan = seg_plan(cell_in.cell_case);
		pa0  = point_at(plan.a0, cell_in.gx, cell_in.gy, s17);
		pb0  = point_at(plan.b0, cell_in.gx, cell_in.gy, s17);
		pa1  = point_at(plan.a1, cell_in.gx, cell_in.gy, s17);
		pb1  = point_at(plan.b1, cell_in.gx, cell_in.gy, s17);
		new_entry.first     = '{start_x: pa0.x, start_y: pa0.y, end_x: pb0.x, end_y: pb0.y};
		new_entry.second    = '{start_x: pa1.x, start_y: pa1.y, end_x: pb1.x, end_y: pb1.y};
		new_entry.cell_case = cell_in.cell_case;
		new_entry.two       = plan.two;
	end

	// Head of the queue drives the output.
	always_comb begin
		head                   = fifo_q[rptr_q];
		seg                    = sub_q ? head.second : head.first;
		segments.valid         = (count_q != '0);
		segments.start_x       = seg.start_x;
		segments.start_y       = seg.start_y;
		segments.end_x         = seg.end_x;
		segments.end_y         = seg.end_y;
		segments.cell_case     = head.cell_case;
		segments.last_segment  = !head.two || sub_q;
		push                   = cell_in.valid;
		fire                   = segments.valid && segments.ready;
		pop                    = fire && (!head.two || sub_q);
	end

	// Every item in the pipeline holds one queue slot in reserve.
	assign room = (SUM_W'(count_q) + SUM_W'(valid_s1) + SUM_W'(cell_in.valid)) <
		SUM_W'(QUEUE_DEPTH);

	// Queue pointers and the saddle sub-index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			sub_q   <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
				sub_q  <= 1'b0;
			end else if (fire) begin
				sub_q <= 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= new_entry;
		end
	end

`ifndef NO_ASSERTIONS
	// The reservation scheme never lets the queue overflow.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_W'(QUEUE_DEPTH)) || pop)
		else $error("segment queue overflow");

	// The fill count stays within the queue depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("segment queue count out of range");

	// The second segment is only ever pending on a saddle entry.
	a_sub_saddle: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (count_q != '0) && head.two)
		else $error("second segment pending on a single-segment entry");
`endif

endmodule

### rtl/marching_squares_contour_core.sv
// A sample item passes through stage 1, stage 2 and the queue before its segment
// item is offered. Throughput: one sample item per cycle while the queue has room.
// A saddle cell gives two segment items; with two of the four queue entries held
// for items in flight, it stalls the input when each following cell emits a segment.
// Reset: arst_n clears raster counters, pipeline valids and the queue, and loads
// the register defaults; the one-bit line buffer is not cleared and needs no sweep.
module marching_squares_contour_core import mscc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mscc_in_if.sink               samples,
	mscc_out_if.source            segments,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t  cfg;
	logic  accept;
	logic  room;
	logic  valid_s1;
	cell_t cell_s2;

	// Sample handshake.
	assign samples.ready = room;
	assign accept        = samples.valid && room;

	mscc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mscc_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.sample         (samples.sample),
		.first_of_frame (samples.first_of_frame),
		.cfg            (cfg),
		.valid_s1       (valid_s1),
		.cell_s2        (cell_s2)
	);

	mscc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.cell_in  (cell_s2),
		.cfg      (cfg),
		.room     (room),
		.segments (segments)
	);

endmodule

### tb/mscc_tb_pkg.sv
`timescale 1ns / 100ps

package mscc_tb_pkg;
	import mscc_pkg::*;

	// One contour segment as it leaves the block.
	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [CASE_W-1:0]  cell_case;
		logic               last_segment;
	} contour_seg_t;

	// Corner weights of the cell index.
	localparam logic [CASE_W-1:0] CORNER_TL = 4'b0001;
	localparam logic [CASE_W-1:0] CORNER_TR = 4'b0010;
	localparam logic [CASE_W-1:0] CORNER_BR = 4'b0100;
	localparam logic [CASE_W-1:0] CORNER_BL = 4'b1000;

	// Tracks the raster position and line buffer, predicts the segments of
	// every accepted sample and compares them against the segment stream.
	class contour_predictor;
		logic signed [SAMPLE_W-1:0] threshold;
		logic [RL_W-1:0]            row_len;
		logic [SIZE_W-1:0]          cell_sz;
		bit                         upper_bits[MAX_ROW_LENGTH];
		bit                         left_active;
		int unsigned                col_pos;
		int unsigned                row_pos;
		contour_seg_t               expected_segments[$];
		int unsigned                mismatches;

		function new();
			threshold   = LEVEL_THRESHOLD_RST;
			row_len     = ROW_LENGTH_RST;
			cell_sz     = CELL_SIZE_RST;
			left_active = 1'b0;
			col_pos     = 0;
			row_pos     = 0;
			mismatches  = 0;
			foreach (upper_bits[i]) upper_bits[i] = 1'b0;
		endfunction

		function void set_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_LEVEL_THRESHOLD: begin
					threshold = value[SAMPLE_W-1:0];
				end
				REG_ROW_LENGTH: begin
					row_len = value[RL_W-1:0];
				end
				REG_CELL_SIZE: begin
					cell_sz = value[SIZE_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Row length as the block uses it, clamped to the supported range.
		function int unsigned effective_length();
			if (row_len < 2) return 2;
			if (row_len > MAX_ROW_LENGTH) return MAX_ROW_LENGTH;
			return row_len;
		endfunction

		// Position of an edge midpoint, wrapped to the coordinate width.
		function void edge_point(pt_t pt, int unsigned gx, int unsigned gy, int unsigned s,
				output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
			int unsigned px;
			int unsigned py;
			case (pt)
				PT_TOP: begin
					px = gx + s;
					py = gy;
				end
				PT_LEFT: begin
					px = gx;
					py = gy + s;
				end
				PT_RIGHT: begin
					px = gx + 2 * s;
					py = gy + s;
				end
				default: begin
					px = gx + s;
					py = gy + 2 * s;
				end
			endcase
			x = px[COORD_W-1:0];
			y = py[COORD_W-1:0];
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] smp, logic fof);
			int unsigned  last;
			int unsigned  col;
			int unsigned  row;
			int unsigned  gx;
			int unsigned  gy;
			int unsigned  s;
			int           n;
			bit           here;
			logic [CASE_W-1:0] corners;
			pt_t          ends[4];
			logic [COORD_W-1:0] ax;
			logic [COORD_W-1:0] ay;
			logic [COORD_W-1:0] bx;
			logic [COORD_W-1:0] by;
			contour_seg_t seg;

			last = effective_length() - 1;
			if (fof) begin
				col_pos = 0;
				row_pos = 0;
			end
			// A column left over from a longer row counts as the last column.
			col  = (col_pos > last) ? last : col_pos;
			row  = row_pos;
			here = (smp >= threshold);

			// The sample closes the cell to its upper left, except in the first
			// column or the first row.
			if (col >= 1 && row >= 1) begin
				corners = {left_active, here, upper_bits[col], upper_bits[col-1]};
				s  = cell_sz;
				gx = 2 * (col - 1) * s;
				gy = 2 * (row - 1) * s;
				n  = 1;
				foreach (ends[i]) ends[i] = PT_TOP;
				case (corners)
					CORNER_TL, CORNER_TR | CORNER_BR | CORNER_BL: begin
						ends[0] = PT_TOP;
						ends[1] = PT_LEFT;
					end
					CORNER_TR, CORNER_TL | CORNER_BR | CORNER_BL: begin
						ends[0] = PT_TOP;
						ends[1] = PT_RIGHT;
					end
					CORNER_BR, CORNER_TL | CORNER_TR | CORNER_BL: begin
						ends[0] = PT_RIGHT;
						ends[1] = PT_BOTTOM;
					end
					CORNER_BL, CORNER_TL | CORNER_TR | CORNER_BR: begin
						ends[0] = PT_BOTTOM;
						ends[1] = PT_LEFT;
					end
					CORNER_TR | CORNER_BR, CORNER_TL | CORNER_BL: begin
						ends[0] = PT_TOP;
						ends[1] = PT_BOTTOM;
					end
					CORNER_TL | CORNER_TR, CORNER_BR | CORNER_BL: begin
						ends[0] = PT_LEFT;
						ends[1] = PT_RIGHT;
					end
					CASE_SADDLE_A: begin
						n       = 2;
						ends[0] = PT_TOP;
						ends[1] = PT_LEFT;
						ends[2] = PT_RIGHT;
						ends[3] = PT_BOTTOM;
					end
					CASE_SADDLE_B: begin
						n       = 2;
						ends[0] = PT_TOP;
						ends[1] = PT_RIGHT;
						ends[2] = PT_BOTTOM;
						ends[3] = PT_LEFT;
					end
					default: begin
						n = 0;
					end
				endcase
				for (int k = 0; k < n; k++) begin
					edge_point(ends[2*k], gx, gy, s, ax, ay);
					edge_point(ends[2*k+1], gx, gy, s, bx, by);
					seg.start_x      = ax;
					seg.start_y      = ay;
					seg.end_x        = bx;
					seg.end_y        = by;
					seg.cell_case    = corners;
					seg.last_segment = (k == n - 1);
					expected_segments.push_back(seg);
				end
			end

			// The line buffer lags one column; the last column also stores itself.
			if (col >= 1) upper_bits[col-1] = left_active;
			if (col == last) upper_bits[col] = here;
			left_active = here;

			if (col == last) begin
				col_pos = 0;
				row_pos = (row + 1 >= MAX_ROWS) ? 0 : row + 1;
			end else begin
				col_pos = col + 1;
				row_pos = row;
			end
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void compare_segment(contour_seg_t got);
			contour_seg_t want;
			if (expected_segments.size() == 0) begin
				$error("unexpected segment (%0d,%0d)-(%0d,%0d) case %0d", got.start_x,
					got.start_y, got.end_x, got.end_y, got.cell_case);
				mismatches++;
				return;
			end
			want = expected_segments.pop_front();
			check_field("start_x", want.start_x, got.start_x);
			check_field("start_y", want.start_y, got.start_y);
			check_field("end_x", want.end_x, got.end_x);
			check_field("end_y", want.end_y, got.end_y);
			check_field("cell_case", want.cell_case, got.cell_case);
			check_field("last_segment", want.last_segment, got.last_segment);
		endfunction
	endclass

endpackage

### tb/tb_marching_squares_contour_core.sv
`timescale 1ns / 100ps

module tb_marching_squares_contour_core;
	import mscc_pkg::*;
	import mscc_tb_pkg::*;

	localparam int HOLD_OFF_CYCLES = 80;
	localparam int SETTLE_CYCLES   = 4;
	localparam int DRAIN_CYCLES    = 8;

	// Rows of a two-sample raster that walk through both saddles and the
	// empty and full cells.
	localparam bit [0:23] DIRECTED_ACTIVE = 24'b100110110000111101100100;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	bit idle_on;
	bit hold_request;

	contour_predictor model = new();

	mscc_in_if  samples_if ();
	mscc_out_if segments_if ();

	marching_squares_contour_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_if),
		.segments (segments_if),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit, far above the slowest correct run.
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Register write: setup cycle, then access cycle until pready.
	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		model.set_register(idx, value);
		@(negedge clk);
	endtask

	// Wait until every expected segment has left and the pipeline is empty.
	task automatic settle();
		while (model.expected_segments.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Write all registers while idle; report whether the row got longer.
	task automatic configure(input int thr, input int rl, input int cs, output bit grew);
		int unsigned old_len;
		settle();
		old_len = model.effective_length();
		cfg_write(REG_LEVEL_THRESHOLD, thr);
		cfg_write(REG_ROW_LENGTH, rl);
		cfg_write(REG_CELL_SIZE, cs);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		grew = model.effective_length() > old_len;
	endtask

	function automatic int random_level();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// A random sample on the chosen side of the threshold.
	function automatic logic signed [SAMPLE_W-1:0] level_sample(input bit active);
		int t;
		int v;
		t = model.threshold;
		if (active) v = t + int'($urandom_range(0, 32767 - t));
		else if (t == -32768) v = t;
		else v = t - 1 - int'($urandom_range(0, t + 32767));
		return v[SAMPLE_W-1:0];
	endfunction

	// Offer one sample item, after a random gap while idling is on, and wait for its acceptance.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic fof);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid          <= 1'b1;
		samples_if.sample         <= smp;
		samples_if.first_of_frame <= fof;
		do @(posedge clk); while (samples_if.ready !== 1'b1);
		model.take_sample(smp, fof);
		@(negedge clk);
	endtask

	// A run of random samples; saddle mode alternates activity like a
	// checkerboard so that every cell is a saddle.
	task automatic stream_samples(input int count, input bit saddle_only, input int fof_odds,
			input bit open_frame);
		logic signed [SAMPLE_W-1:0] v;
		int t;
		bit fof;
		for (int k = 0; k < count; k++) begin
			fof = (k == 0 && open_frame) || (fof_odds > 0 && $urandom_range(1, fof_odds) == 1);
			if (saddle_only) begin
				v = level_sample(((k + k / 4) % 2) == 1);
			end else begin
				case ($urandom_range(0, 3))
					0: v = SAMPLE_W'($urandom_range(0, 65535));
					1: begin
						t = model.threshold + int'($urandom_range(0, 3)) - 2;
						if (t < -32768) t = -32768;
						if (t > 32767) t = 32767;
						v = t[SAMPLE_W-1:0];
					end
					default: v = level_sample($urandom_range(0, 1) == 1);
				endcase
			end
			send_sample(v, fof);
		end
		samples_if.valid <= 1'b0;
	endtask

	// Segment receiver with random stalls while idling is on and one long hold-off on request.
	initial begin : segment_sink
		int stall;
		contour_seg_t got;
		segments_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				segments_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				stall = idle_on ? $urandom_range(0, 5) : 0;
				if (stall > 0) begin
					segments_if.ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			segments_if.ready <= 1'b1;
			do @(posedge clk); while (segments_if.valid !== 1'b1);
			got.start_x      = segments_if.start_x;
			got.start_y      = segments_if.start_y;
			got.end_x        = segments_if.end_x;
			got.end_y        = segments_if.end_y;
			got.cell_case    = segments_if.cell_case;
			got.last_segment = segments_if.last_segment;
			model.compare_segment(got);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic signed [SAMPLE_W-1:0] v;
		bit grew;

		arst_n                    = 1'b0;
		psel                      = 1'b0;
		penable                   = 1'b0;
		pwrite                    = 1'b0;
		paddr                     = '0;
		pwdata                    = '0;
		samples_if.valid          = 1'b0;
		samples_if.sample         = '0;
		samples_if.first_of_frame = 1'b0;
		idle_on                   = 1'b1;
		hold_request              = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed rows on a two-sample raster at the largest cell size,
		// with samples at the field extremes and right at the threshold.
		configure(0, 2, 255, grew);
		for (int k = 0; k < 24; k++) begin
			if (DIRECTED_ACTIVE[k]) v = k[0] ? 16'h0000 : 16'h7FFF;
			else v = k[0] ? 16'hFFFF : 16'h8000;
			send_sample(v, k == 0);
		end
		samples_if.valid <= 1'b0;

		// Short rows with occasional frame restarts.
		configure(0, 5, 10, grew);
		stream_samples(40, 1'b0, 40, grew || $urandom_range(0, 1));

		// Lowest threshold: every corner active, so no segments at all.
		configure(-32768, 3, 1, grew);
		stream_samples(12, 1'b0, 0, grew || $urandom_range(0, 1));

		// Highest threshold, row length above the maximum, no idling; one full
		// row and the start of the next.
		idle_on = 1'b0;
		configure(32767, 511, 255, grew);
		stream_samples(260, 1'b0, 0, 1'b1);

		// Row length below the minimum and zero cell size, continuing the old
		// frame so that the stale column is reached.
		idle_on = 1'b1;
		configure(random_level(), 0, 0, grew);
		stream_samples(60, 1'b0, 0, 1'b0);

		// Saddle-only raster while the receiver holds off and the sender never
		// idles, so the block fills and stalls its input.
		idle_on = 1'b0;
		configure(random_level(), 4, $urandom_range(1, 255), grew);
		@(posedge clk);
		hold_request = 1'b1;
		@(negedge clk);
		stream_samples(48, 1'b1, 0, 1'b1);

		// Random settings to finish.
		idle_on = 1'b1;
		repeat (2) begin
			configure(random_level(), $urandom_range(2, 12), $urandom_range(1, 255), grew);
			stream_samples(30, 1'b0, 25, grew || $urandom_range(0, 1));
		end

		// Drain the remaining segments, then give the verdict.
		while (model.expected_segments.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (model.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
